>>> hdl/dsum_pkg.sv
// Package for the divisor-sum unit: sieve and prime table sizes, field widths.
// No dependencies.
`default_nettype none
package dsum_pkg;
	localparam int SIEVE_LIMIT = 65536;
	localparam int MAX_PRIMES  = 6542;
	localparam int MAP_DEPTH   = SIEVE_LIMIT + 1;
	localparam int MAP_AW      = $clog2(MAP_DEPTH);
	localparam int LIST_AW     = $clog2(MAX_PRIMES);
	localparam int ROOT_LIMIT  = 256;
	localparam int VAL_W       = 32;
	localparam int SUM_W       = 35;
	localparam int PRIME_W     = 16;
endpackage
`default_nettype wire

>>> hdl/divisor_sum_by_prime_table_unit.sv
// Divisor-sum unit: sieve-built prime table and trial division with a shared divider.
// Depends on dsum_pkg and dsum_ram.
//
// channel   ports                    transfer when
// input     start, busy, value       start high and busy low at a rising edge
// result    done, divisor_sum        done high for one cycle
//
// Reset: a clear pass sets the map to ones, then the sieve scans each index and
// marks the multiples of each prime up to the root limit; busy stays high.
// For each tried prime an item reads the table, squares and compares, runs the
// bit-serial divider, checks the remainder and multiplies in two halves; each
// repeated factor reruns the divider and check, and a cofactor above one gets a final multiply.
// A value of 0 gives its result in the cycle after the transfer; the receiver cannot stall.
`default_nettype none
module divisor_sum_by_prime_table_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [dsum_pkg::VAL_W-1:0] value,
	output logic                           done,
	output logic [dsum_pkg::SUM_W-1:0]     divisor_sum
);
	typedef enum logic [11:0] {
		ST_CLR     = 12'b000000000001,
		ST_SCAN_RD = 12'b000000000010,
		ST_SCAN_CK = 12'b000000000100,
		ST_MARK    = 12'b000000001000,
		ST_IDLE    = 12'b000000010000,
		ST_Q_RD    = 12'b000000100000,
		ST_Q_SQ    = 12'b000001000000,
		ST_Q_CMP   = 12'b000010000000,
		ST_DIV     = 12'b000100000000,
		ST_DIV_CK  = 12'b001000000000,
		ST_MUL_LO  = 12'b010000000000,
		ST_MUL_HI  = 12'b100000000000
	} state_t;

	localparam int MAW = dsum_pkg::MAP_AW;
	localparam int LAW = dsum_pkg::LIST_AW;

	state_t                        state_q;
	logic [MAW-1:0]                clr_q;
	logic [MAW-1:0]                i_q;
	logic [MAW:0]                  j_q;
	logic [LAW-1:0]                cnt_q;
	logic [LAW-1:0]                k_q;
	logic [dsum_pkg::VAL_W-1:0]    n_q;
	logic [dsum_pkg::PRIME_W-1:0]  p_q;
	logic [31:0]                   sq_q;
	logic [32:0]                   part_q;
	logic [32:0]                   power_q;
	logic [15:0]                   rem_q;
	logic [31:0]                   quo_q;
	logic [4:0]                    div_cnt_q;
	logic [dsum_pkg::SUM_W-1:0]    prod_q;
	logic [dsum_pkg::SUM_W-1:0]    acc_q;
	logic [32:0]                   mul_b_q;
	logic                          last_q;
	logic                          done_q;

	logic                          map_we;
	logic [MAW-1:0]                map_waddr;
	logic                          map_wdata;
	logic                          map_rdata;
	logic                          list_we;
	logic [dsum_pkg::PRIME_W-1:0]  list_rdata;
	logic [16:0]                   trial;
	logic                          trial_ge;
	logic [MAW:0]                  j_next;
	logic [50:0]                   lo_prod;
	logic [50:0]                   hi_prod;
	logic [48:0]                   pow_prod;

	// Memory control for the sieve map and the prime list.
	assign map_we    = (state_q == ST_CLR) || (state_q == ST_MARK);
	assign map_waddr = (state_q == ST_CLR) ? clr_q : j_q[MAW-1:0];
	assign map_wdata = (state_q == ST_CLR);
	assign list_we   = (state_q == ST_SCAN_CK) && map_rdata &&
		(cnt_q < LAW'(dsum_pkg::MAX_PRIMES));

	dsum_ram #(.WIDTH(1), .DEPTH(dsum_pkg::MAP_DEPTH)) u_map (
		.clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
		.raddr(i_q), .rdata(map_rdata)
	);

	dsum_ram #(.WIDTH(dsum_pkg::PRIME_W), .DEPTH(dsum_pkg::MAX_PRIMES)) u_list (
		.clk(clk), .we(list_we), .waddr(cnt_q), .wdata(i_q[dsum_pkg::PRIME_W-1:0]),
		.raddr(k_q), .rdata(list_rdata)
	);

	// Shared datapath pieces: divider step, marking stride, multiplies.
	assign trial    = {rem_q, quo_q[31]};
	assign trial_ge = trial >= {1'b0, p_q};
	assign j_next   = j_q + {1'b0, i_q};
	assign lo_prod  = 51'(prod_q * mul_b_q[15:0]);
	assign hi_prod  = 51'(prod_q * mul_b_q[32:16]);
	assign pow_prod = 49'(power_q * p_q);

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign divisor_sum = prod_q;

	// Sequencer: clear pass, sieve, then one query at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			i_q       <= MAW'(2);
			j_q       <= '0;
			cnt_q     <= '0;
			k_q       <= '0;
			div_cnt_q <= '0;
			last_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAW'(dsum_pkg::SIEVE_LIMIT)) begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CK;
				end
				ST_SCAN_CK: begin
					if (list_we) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (map_rdata && (i_q <= MAW'(dsum_pkg::ROOT_LIMIT))) begin
						j_q     <= (MAW+1)'(i_q[8:0] * i_q[8:0]);
						state_q <= ST_MARK;
					end else if (i_q == MAW'(dsum_pkg::SIEVE_LIMIT)) begin
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_MARK: begin
					j_q <= j_next;
					if (j_next > (MAW+1)'(dsum_pkg::SIEVE_LIMIT)) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_IDLE: begin
					if (start) begin
						n_q    <= value;
						k_q    <= '0;
						last_q <= 1'b0;
						if (value == '0) begin
							prod_q <= '0;
							done_q <= 1'b1;
						end else begin
							prod_q  <= dsum_pkg::SUM_W'(1);
							state_q <= ST_Q_RD;
						end
					end
				end
				ST_Q_RD: begin
					if (k_q == cnt_q) begin
						if (n_q != 32'd1) begin
							mul_b_q <= {1'b0, n_q} + 33'd1;
							last_q  <= 1'b1;
							state_q <= ST_MUL_LO;
						end else begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_Q_SQ;
					end
				end
				ST_Q_SQ: begin
					p_q     <= list_rdata;
					sq_q    <= list_rdata * list_rdata;
					state_q <= ST_Q_CMP;
				end
				ST_Q_CMP: begin
					if (sq_q > n_q) begin
						k_q     <= cnt_q;
						state_q <= ST_Q_RD;
					end else begin
						part_q    <= 33'd1;
						power_q   <= {17'd0, p_q};
						rem_q     <= '0;
						quo_q     <= n_q;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= trial_ge ? 16'(trial - {1'b0, p_q}) : trial[15:0];
					quo_q     <= {quo_q[30:0], trial_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'd31) begin
						state_q <= ST_DIV_CK;
					end
				end
				ST_DIV_CK: begin
					if (rem_q == '0) begin
						n_q       <= quo_q;
						part_q    <= part_q + power_q;
						power_q   <= pow_prod[32:0];
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						mul_b_q <= part_q;
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: begin
					acc_q   <= lo_prod[dsum_pkg::SUM_W-1:0];
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					prod_q <= acc_q + {hi_prod[dsum_pkg::SUM_W-17:0], 16'd0};
					if (last_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_Q_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// After a clean division step the remainder and step count restart; quo_q keeps the quotient.
	// (quo_q is loaded from n_q only when the first division for a prime begins.)

	// A zero item answers zero on the next cycle.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && value == '0 |=> done && divisor_sum == '0)
		else $error("zero input did not give a zero result");

	// A zero sum only ever comes from a zero item.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && divisor_sum == '0 |-> $past(start && !busy && value == '0))
		else $error("zero sum for a nonzero item");

	// The prime table never exceeds its capacity.
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAW'(dsum_pkg::MAX_PRIMES))
		else $error("prime count overflow");

	// The divider remainder stays below the divisor.
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV_CK |-> rem_q < p_q)
		else $error("divider remainder out of range");
endmodule
`default_nettype wire

>>> hdl/dsum_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module dsum_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> dv/divisor_sum_by_prime_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for divisor_sum_by_prime_table_unit: directed values, then random ones.
// Depends on dsum_pkg; expected sums are typed or come from a local sieve and trial division.
`default_nettype none
module divisor_sum_by_prime_table_unit_tb;

	localparam int RANDOM_ITEMS = 84;

	typedef struct {
		logic [dsum_pkg::VAL_W-1:0] n;
		bit                         typed;
		logic [dsum_pkg::SUM_W-1:0] sum;
	} sum_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic [dsum_pkg::VAL_W-1:0] value;
	wire                        busy;
	wire                        done;
	wire [dsum_pkg::SUM_W-1:0]  divisor_sum;

	logic [dsum_pkg::SUM_W-1:0] pending_sums[$];
	int unsigned                prime_tbl[dsum_pkg::MAX_PRIMES];
	int unsigned                prime_total;
	int                         fail_count;

	sum_row_t directed_rows[] = '{
		'{32'd0,          1'b1, 35'd0},
		'{32'd1,          1'b1, 35'd1},
		'{32'd2,          1'b1, 35'd3},
		'{32'd3,          1'b1, 35'd4},
		'{32'd4,          1'b0, 35'd0},
		'{32'd12,         1'b0, 35'd0},
		'{32'd65536,      1'b1, 35'd131071},
		'{32'd65537,      1'b1, 35'd65538},
		'{32'd65521,      1'b1, 35'd65522},
		'{32'h8000_0000,  1'b1, 35'd4294967295},
		'{32'hFFFF_FFFF,  1'b1, 35'd7304603328},
		'{32'd4294967291, 1'b1, 35'd4294967292},
		'{32'd4293001441, 1'b0, 35'd0},
		'{32'd3491888400, 1'b0, 35'd0},
		'{32'h5555_5555,  1'b0, 35'd0},
		'{32'hAAAA_AAAA,  1'b0, 35'd0}
	};

	divisor_sum_by_prime_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.done       (done),
		.divisor_sum(divisor_sum)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Sieve of Eratosthenes over the same range as the block, primes kept in order.
	function automatic void sieve_primes();
		bit is_comp[] = new[dsum_pkg::SIEVE_LIMIT + 1];
		prime_total = 0;
		for (int i = 2; i <= dsum_pkg::SIEVE_LIMIT; i++) begin
			if (!is_comp[i]) begin
				for (longint j = longint'(i) * i; j <= dsum_pkg::SIEVE_LIMIT; j += i)
					is_comp[j] = 1'b1;
				if (prime_total < dsum_pkg::MAX_PRIMES) begin
					prime_tbl[prime_total] = i;
					prime_total++;
				end
			end
		end
	endfunction

	// Sigma by trial division over the prime table; the cofactor left over is prime.
	function automatic logic [dsum_pkg::SUM_W-1:0] sigma_of(logic [dsum_pkg::VAL_W-1:0] n_in);
		logic [63:0] n, product, p, power, part;
		n = n_in;
		product = 1;
		if (n == 0)
			return '0;
		for (int k = 0; k < prime_total; k++) begin
			p = prime_tbl[k];
			if (p * p > n)
				break;
			power = p;
			part = 1;
			while (n % p == 0) begin
				n = n / p;
				part += power;
				power *= p;
			end
			product *= part;
		end
		if (n != 1)
			product *= (n + 1);
		return product[dsum_pkg::SUM_W-1:0];
	endfunction

	// Present one value and hold it until the block takes it; a burst keeps start high.
	task automatic send_value(logic [dsum_pkg::VAL_W-1:0] n, bit typed,
			logic [dsum_pkg::SUM_W-1:0] sum, ref int burst_left);
		int gap;
		start <= 1'b1;
		value <= n;
		do
			@(posedge clk);
		while (busy);
		pending_sums = {pending_sums, (typed ? sum : sigma_of(n))};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(0, 5);
		end
	endtask

	// Each strobed result is checked against the oldest outstanding sum.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_sums.size() == 0) begin
				$error("divisor_sum: unexpected result %0d", divisor_sum);
				fail_count++;
			end else begin
				if (divisor_sum !== pending_sums[0]) begin
					$error("divisor_sum: expected %0d, got %0d", pending_sums[0], divisor_sum);
					fail_count++;
				end
				void'(pending_sums.pop_front());
			end
		end
	end

	// Stimulus: directed rows, then random values kept mostly small to bound run time.
	initial begin
		int burst_left;
		int width;
		logic [dsum_pkg::VAL_W-1:0] n;
		fail_count = 0;
		burst_left = 0;
		start = 1'b0;
		value = '0;
		arst_n = 1'b0;
		sieve_primes();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send_value(directed_rows[i].n, directed_rows[i].typed, directed_rows[i].sum,
				burst_left);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 11) == 0) begin
				n = dsum_pkg::VAL_W'($urandom_range(1, 4095)) << $urandom_range(12, 20);
			end else begin
				width = $urandom_range(1, 20);
				n = $urandom & ((32'd1 << width) - 1);
			end
			send_value(n, 1'b0, '0, burst_left);
		end
		start <= 1'b0;
		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending_sums.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit: sieve, two full walks of the prime table and the small items, several times over.
	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire
